// ===== rtl/core/data_run_list_decoder_macros.svh =====
// Assertion macros shared by the data run list decoder checker.
`ifndef DATA_RUN_LIST_DECODER_MACROS_SVH
`define DATA_RUN_LIST_DECODER_MACROS_SVH

// Checked only out of reset.
`define DRLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DRLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/drld_pkg.sv =====
// Types and constants of the data run list decoder.
package drld_pkg;

  localparam logic [3:0] MaxFieldBytes = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       list_start;
  } in_word_t;

  typedef struct packed {
    logic [63:0] start_cluster;
    logic [63:0] cluster_count;
    logic        list_end;
  } out_word_t;

endpackage

// ===== rtl/core/data_run_list_decoder.sv =====
// Data run list decoder: header, length and offset bytes to cluster runs.
//
// Takes one run list byte per word and returns one word for each run: its
// absolute start cluster and cluster count, or an end marker when a zero
// length ends the list. A byte with list_start set is a header and clears the
// running cluster number. The block accepts a byte every cycle while the
// output is not stalled; a byte is held in the input register and its
// result, if any, is written to the output register once the output is free,
// so a run passes through the input register and then the output register.
// A stalled output holds one word plus one byte.
module data_run_list_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  drld_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output drld_pkg::out_word_t out_word_o
);
  import drld_pkg::*;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhLength = 4'b0010,
    PhOffset = 4'b0100,
    PhEnded  = 4'b1000
  } phase_e;

  function automatic logic [63:0] sign_extend(input logic [63:0] d, input logic [3:0] kept);
    logic        sign;
    logic [63:0] r;
    r    = d;
    sign = 1'b0;
    for (int j = 1; j < 8; j++) begin
      if (kept == 4'(j)) sign = d[8*j-1];
    end
    for (int j = 1; j < 8; j++) begin
      if (sign && (4'(j) >= kept)) r[8*j +: 8] = 8'hFF;
    end
    return r;
  endfunction

  function automatic logic [63:0] gather(input logic [63:0] acc, input logic [7:0] b,
                                         input logic [3:0] pos);
    logic [63:0] r;
    r = acc;
    if (pos < MaxFieldBytes) r = acc | ({56'd0, b} << {pos[2:0], 3'b000});
    return r;
  endfunction

  in_word_t    in_q;
  logic        in_vld_q;
  out_word_t   out_q, res;
  logic        out_vld_q;
  logic        res_vld, advance;

  phase_e      phase_q, phase_d;
  logic [3:0]  len_tot_q, len_tot_d, off_tot_q, off_tot_d, pos_q, pos_d, pos_inc, kept;
  logic [63:0] len_q, len_d, dlt_q, dlt_d, run_q, run_d, len_g, dlt_g, run_sum;

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  assign pos_inc = pos_q + 4'd1;
  assign len_g   = gather(len_q, in_q.data_byte, pos_q);
  assign dlt_g   = gather(dlt_q, in_q.data_byte, pos_q);
  assign kept    = (off_tot_q > MaxFieldBytes) ? MaxFieldBytes : off_tot_q;
  assign run_sum = run_q + sign_extend(dlt_g, kept);

  always_comb begin
    phase_d   = phase_q;
    len_tot_d = len_tot_q;
    off_tot_d = off_tot_q;
    pos_d     = pos_q;
    len_d     = len_q;
    dlt_d     = dlt_q;
    run_d     = run_q;
    res_vld   = 1'b0;
    res       = '0;
    if (in_q.list_start || (phase_q == PhHeader)) begin
      if (in_q.list_start) run_d = '0;
      len_tot_d = in_q.data_byte[3:0];
      off_tot_d = in_q.data_byte[7:4];
      pos_d     = '0;
      len_d     = '0;
      dlt_d     = '0;
      if (in_q.data_byte[3:0] == 4'd0) begin
        res_vld      = 1'b1;
        res.list_end = 1'b1;
        phase_d      = PhEnded;
      end else begin
        phase_d = PhLength;
      end
    end else begin
      unique case (phase_q)
        PhLength: begin
          len_d = len_g;
          pos_d = pos_inc;
          if (pos_inc == len_tot_q) begin
            if (len_g == '0) begin
              res_vld      = 1'b1;
              res.list_end = 1'b1;
              phase_d      = PhEnded;
            end else if (off_tot_q == 4'd0) begin
              res_vld           = 1'b1;
              res.start_cluster = run_q;
              res.cluster_count = len_g;
              phase_d           = PhHeader;
            end else begin
              pos_d   = '0;
              phase_d = PhOffset;
            end
          end
        end
        PhOffset: begin
          dlt_d = dlt_g;
          pos_d = pos_inc;
          if (pos_inc == off_tot_q) begin
            run_d             = run_sum;
            res_vld           = 1'b1;
            res.start_cluster = run_sum;
            res.cluster_count = len_q;
            phase_d           = PhHeader;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PhHeader;
      len_tot_q <= '0;
      off_tot_q <= '0;
      pos_q     <= '0;
      len_q     <= '0;
      dlt_q     <= '0;
      run_q     <= '0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= res_vld;
        phase_q   <= phase_d;
        len_tot_q <= len_tot_d;
        off_tot_q <= off_tot_d;
        pos_q     <= pos_d;
        len_q     <= len_d;
        dlt_q     <= dlt_d;
        run_q     <= run_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_word_i;
    if (advance && res_vld) out_q <= res;
  end

endmodule

// ===== rtl/core/drld_checker.sv =====
// Port checker for the data run list decoder, bound to the top level.
`include "data_run_list_decoder_macros.svh"

module drld_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input drld_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input drld_pkg::out_word_t out_word_o
);
  import drld_pkg::*;

  `DRLD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o), "output word changed while stalled")
  `DRLD_ASSERT(a_end_zero, out_valid_o && out_word_o.list_end |-> out_word_o.start_cluster == '0 && out_word_o.cluster_count == '0, "end marker with nonzero fields")
  `DRLD_ASSERT(a_run_nonzero, out_valid_o && !out_word_o.list_end |-> out_word_o.cluster_count != '0, "run word with zero cluster count")
  `DRLD_ASSERT(a_ready_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "input blocked without output stall")

endmodule

bind data_run_list_decoder drld_checker u_drld_checker (.*);
